// ===== design/slmp_pkg.sv =====
// Shared mode codes and controller/datapath interface types for the merge-path unit.
`default_nettype none

package slmp_pkg;

  localparam logic [1:0] MODE_APPEND_A = 2'd0;
  localparam logic [1:0] MODE_APPEND_B = 2'd1;
  localparam logic [1:0] MODE_MERGE    = 2'd2;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic set_ovf;
    logic start_merge;
    logic div_step;
    logic search_init;
    logic search_issue;
    logic search_eval;
    logic set_bound;
    logic merge_emit;
    logic advance;
    logic finish;
  } slmp_cmd_t;

  typedef struct packed {
    logic full_a;
    logic full_b;
    logic div_busy;
    logic last_part;
    logic search_done;
    logic seg_done;
    logic out_free;
  } slmp_status_t;

endpackage

`default_nettype wire

// ===== design/slmp_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module slmp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/slmp_ctrl.sv =====
// Controller state machine: load, diagonal split search and segment merge sequencing.
`default_nettype none

module slmp_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            mode,
  input  wire slmp_pkg::slmp_status_t status,
  output slmp_pkg::slmp_cmd_t        cmd
);
  import slmp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SRCH_ISSUE,
    S_SRCH_EVAL,
    S_BOUND,
    S_SEG,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority if (mode == MODE_APPEND_A) begin
            cmd.load_a  = !status.full_a;
            cmd.set_ovf = status.full_a;
          end else if (mode == MODE_APPEND_B) begin
            cmd.load_b  = !status.full_b;
            cmd.set_ovf = status.full_b;
          end else if (mode == MODE_MERGE) begin
            cmd.start_merge = 1'b1;
            state_next      = S_DIV;
          end else begin
            // unused code: transaction is taken and ignored
          end
        end
      end
      S_DIV: begin
        priority if (status.div_busy) begin
          cmd.div_step = 1'b1;
        end else if (status.last_part) begin
          state_next = S_BOUND;
        end else begin
          cmd.search_init = 1'b1;
          state_next      = S_SRCH_ISSUE;
        end
      end
      S_SRCH_ISSUE: begin
        if (status.search_done) begin
          state_next = S_BOUND;
        end else begin
          cmd.search_issue = 1'b1;
          state_next       = S_SRCH_EVAL;
        end
      end
      S_SRCH_EVAL: begin
        cmd.search_eval = 1'b1;
        state_next      = S_SRCH_ISSUE;
      end
      S_BOUND: begin
        cmd.set_bound = 1'b1;
        state_next    = S_SEG;
      end
      S_SEG: begin
        priority if (!status.seg_done) begin
          state_next = S_EMIT;
        end else if (status.last_part) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_DIV;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.merge_emit = 1'b1;
          state_next     = S_SEG;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/slmp_dp.sv =====
// Datapath: list stores, counts, split search, segment merge and result register.
`default_nettype none

module slmp_dp #(
  parameter int LIST_DEPTH = 32,
  parameter int PARTS      = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire slmp_pkg::slmp_cmd_t cmd,
  output slmp_pkg::slmp_status_t   status,
  input  wire logic signed [31:0]  value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [31:0]       merged_value,
  output logic                     from_list_b,
  output logic                     last,
  output logic                     dropped
);
  import slmp_pkg::*;

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int TW = $clog2(2 * LIST_DEPTH + 1);
  localparam int PW = $clog2(PARTS + 1);
  localparam int RW = $clog2(PARTS + 2 * LIST_DEPTH + 1);

  logic [CW-1:0] count_a, count_b;
  logic          ovf;
  logic [PW-1:0] part;
  logic [TW-1:0] quot;
  logic [RW-1:0] rem;
  logic [CW-1:0] lo, hi;
  logic [CW-1:0] mid_r;
  logic [TW-1:0] j_r;
  logic [CW-1:0] prev_a, prev_b;
  logic [CW-1:0] cur_a, cur_b;
  logic [TW-1:0] kout;

  logic [TW-1:0] total;
  logic [CW-1:0] mid_c;
  logic [TW-1:0] j_c, jm1_c;
  logic [AW-1:0] raddr_a, raddr_b;
  logic [31:0]   rd_a, rd_b;
  logic          go_right;
  logic          i_more, j_more, take_a;
  logic          out_free;

  assign total = TW'(count_a) + TW'(count_b);
  assign mid_c = lo + ((hi - lo) >> 1);
  assign j_c   = quot - TW'(mid_c);
  assign jm1_c = j_c - TW'(1);

  assign raddr_a = cmd.search_issue ? mid_c[AW-1:0] : prev_a[AW-1:0];
  assign raddr_b = cmd.search_issue ? jm1_c[AW-1:0] : prev_b[AW-1:0];

  slmp_ram #(.WIDTH(32), .DEPTH(LIST_DEPTH)) u_store_a (
    .clk   (clk),
    .we    (cmd.load_a),
    .waddr (count_a[AW-1:0]),
    .wdata (value),
    .raddr (raddr_a),
    .rdata (rd_a)
  );

  slmp_ram #(.WIDTH(32), .DEPTH(LIST_DEPTH)) u_store_b (
    .clk   (clk),
    .we    (cmd.load_b),
    .waddr (count_b[AW-1:0]),
    .wdata (value),
    .raddr (raddr_b),
    .rdata (rd_b)
  );

  // B element before the diagonal is larger than the A element on it: split moves right
  assign go_right = (j_r != '0) && (j_r <= TW'(count_b)) && (mid_r < count_a) &&
                    ($signed(rd_b) > $signed(rd_a));

  assign i_more = prev_a < cur_a;
  assign j_more = prev_b < cur_b;
  // ties go to B
  assign take_a = i_more && (!j_more || ($signed(rd_a) < $signed(rd_b)));

  assign out_free = !out_valid || !out_stall;

  assign status.full_a      = (count_a == CW'(LIST_DEPTH));
  assign status.full_b      = (count_b == CW'(LIST_DEPTH));
  assign status.div_busy    = (rem >= RW'(PARTS));
  assign status.last_part   = (part == PW'(PARTS));
  assign status.search_done = (lo >= hi);
  // segment ends at its own diagonal, even if an unordered list leaves elements over
  assign status.seg_done    = (kout == (TW'(cur_a) + TW'(cur_b)));
  assign status.out_free    = out_free;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count_a   <= '0;
      count_b   <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_a) begin
        count_a <= count_a + CW'(1);
      end
      if (cmd.load_b) begin
        count_b <= count_b + CW'(1);
      end
      if (cmd.set_ovf) begin
        ovf <= 1'b1;
      end
      if (cmd.finish) begin
        count_a <= '0;
        count_b <= '0;
        ovf     <= 1'b0;
      end
      if (cmd.merge_emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // merge sequencing registers
  always_ff @(posedge clk) begin
    if (cmd.start_merge) begin
      part   <= PW'(1);
      quot   <= '0;
      rem    <= RW'(total);
      prev_a <= '0;
      prev_b <= '0;
      cur_a  <= '0;
      cur_b  <= '0;
      kout   <= '0;
    end
    // d = floor(part * total / PARTS), kept as quot with remainder rem
    if (cmd.div_step) begin
      rem  <= rem - RW'(PARTS);
      quot <= quot + TW'(1);
    end
    if (cmd.advance) begin
      part <= part + PW'(1);
      rem  <= rem + RW'(total);
    end
    if (cmd.search_init) begin
      lo <= (quot > TW'(count_b)) ? CW'(quot - TW'(count_b)) : '0;
      hi <= (quot < TW'(count_a)) ? CW'(quot) : count_a;
    end
    if (cmd.search_issue) begin
      mid_r <= mid_c;
      j_r   <= j_c;
    end
    if (cmd.search_eval) begin
      if (go_right) begin
        lo <= mid_r + CW'(1);
      end else begin
        hi <= mid_r;
      end
    end
    // each segment starts from the previous split point
    if (cmd.set_bound) begin
      prev_a <= cur_a;
      prev_b <= cur_b;
      if (status.last_part) begin
        cur_a <= count_a;
        cur_b <= count_b;
      end else begin
        cur_a <= lo;
        cur_b <= CW'(quot - TW'(lo));
      end
    end
    if (cmd.merge_emit) begin
      if (take_a) begin
        prev_a <= prev_a + CW'(1);
      end else begin
        prev_b <= prev_b + CW'(1);
      end
      kout <= kout + TW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.merge_emit) begin
      merged_value <= take_a ? rd_a : rd_b;
      from_list_b  <= !take_a;
      last         <= ((kout + TW'(1)) == total);
      dropped      <= ovf;
    end
  end

endmodule

`default_nettype wire

// ===== design/sorted_list_merge_path_unit.sv =====
// Load: list transactions and mode 3 (taken and ignored) never stall the input.
// Merge: for each of PARTS segments, up to ceil(total/PARTS) divide steps plus, for all but
// the last segment, a binary split search whose steps each do a RAM read, then a compare;
// each result takes a registered store read, then a select. Results leave through an output
// register. Input is stalled for the whole merge. Reset clears counts, drop flag and control;
// list contents are left as they were.
`default_nettype none

module sorted_list_merge_path_unit #(
  parameter int LIST_DEPTH = 32,
  parameter int PARTS      = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         mode,
  input  wire logic signed [31:0] value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      merged_value,
  output logic                    from_list_b,
  output logic                    last,
  output logic                    dropped
);
  import slmp_pkg::*;

  slmp_cmd_t    cmd;
  slmp_status_t status;

  slmp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .status   (status),
    .cmd      (cmd)
  );

  slmp_dp #(.LIST_DEPTH(LIST_DEPTH), .PARTS(PARTS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .merged_value (merged_value),
    .from_list_b  (from_list_b),
    .last         (last),
    .dropped      (dropped)
  );

  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.merge_emit |-> status.out_free)
    else $error("result register overwritten while a transaction is pending");

  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && mode != MODE_MERGE) |=> !in_stall)
    else $error("non-merge transaction held the input");

  a_single_input_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_a, cmd.load_b, cmd.set_ovf, cmd.start_merge}))
    else $error("conflicting input commands");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (!status.full_a && !in_stall))
    else $error("merge did not return to idle with lists emptied");

endmodule

`default_nettype wire

// ===== bench/tb_sorted_list_merge_path_unit.sv =====
// Self-checking bench for the merge path unit: directed table, then random list loads and merges.
module tb_sorted_list_merge_path_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import slmp_pkg::*;

  localparam int LIST_DEPTH = 32;
  localparam int PARTS      = 4;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic FROM_A = 1'b0;
  localparam logic FROM_B = 1'b1;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    logic signed [31:0] val;
    logic               from_b;
    logic               last;
    logic               drop;
  } merged_t;

  // n_typed < 0: expectation comes from the predictor
  typedef struct {
    logic [1:0]         mode;
    logic signed [31:0] value;
    int                 n_typed;
  } dir_row_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         mode = MODE_APPEND_A;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] merged_value;
  logic               from_list_b;
  logic               last;
  logic               dropped;

  // predictor state
  logic signed [31:0] list_a [LIST_DEPTH];
  logic signed [31:0] list_b [LIST_DEPTH];
  int                 fill_a = 0;
  int                 fill_b = 0;
  logic               drop_flag = 1'b0;

  merged_t  merged_run[$];
  merged_t  pending_out[$];
  merged_t  typed_out[$];
  dir_row_t dir_rows[$];
  logic signed [31:0] run_vals[$];

  int errors = 0;
  int n_items = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_merges = 0;
  int n_drop_results = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_ask = 0;

  sorted_list_merge_path_unit #(
    .LIST_DEPTH(LIST_DEPTH),
    .PARTS(PARTS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .merged_value(merged_value),
    .from_list_b(from_list_b),
    .last(last),
    .dropped(dropped)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Number of A elements among the first d merged elements (binary search on one diagonal).
  function automatic int diag_split(int d, int m, int n);
    int lo, hi, mid, j;
    lo = (d > n) ? d - n : 0;
    hi = (d < m) ? d : m;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      j = d - mid;
      if (j > 0 && j <= n && mid < m && list_b[j - 1] > list_a[mid]) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // Applies one transaction to the predictor; merge results land in merged_run.
  function automatic void apply_item(logic [1:0] m, logic signed [31:0] v);
    int total, p, d, i, ie, j, je, k;
    int pa[PARTS + 1];
    int pb[PARTS + 1];
    merged_t slot[2 * LIST_DEPTH];
    merged_run.delete();
    case (m)
      MODE_APPEND_A: begin
        if (fill_a < LIST_DEPTH) begin
          list_a[fill_a] = v;
          fill_a++;
        end else drop_flag = 1'b1;
      end
      MODE_APPEND_B: begin
        if (fill_b < LIST_DEPTH) begin
          list_b[fill_b] = v;
          fill_b++;
        end else drop_flag = 1'b1;
      end
      MODE_MERGE: begin
        total = fill_a + fill_b;
        pa[0] = 0;
        pb[0] = 0;
        pa[PARTS] = fill_a;
        pb[PARTS] = fill_b;
        for (p = 1; p < PARTS; p++) begin
          d = (p * total) / PARTS;
          pa[p] = diag_split(d, fill_a, fill_b);
          pb[p] = d - pa[p];
        end
        // segments may overlap when the lists are not sorted; later writes win
        for (p = 0; p < PARTS; p++) begin
          i = pa[p];
          ie = pa[p + 1];
          j = pb[p];
          je = pb[p + 1];
          k = i + j;
          while (i < ie && j < je) begin
            if (list_a[i] < list_b[j]) begin
              slot[k % (2 * LIST_DEPTH)] = '{list_a[i], FROM_A, 1'b0, drop_flag};
              i++;
            end else begin
              slot[k % (2 * LIST_DEPTH)] = '{list_b[j], FROM_B, 1'b0, drop_flag};
              j++;
            end
            k++;
          end
          while (i < ie) begin
            slot[k % (2 * LIST_DEPTH)] = '{list_a[i], FROM_A, 1'b0, drop_flag};
            i++;
            k++;
          end
          while (j < je) begin
            slot[k % (2 * LIST_DEPTH)] = '{list_b[j], FROM_B, 1'b0, drop_flag};
            j++;
            k++;
          end
        end
        if (total > 0) slot[total - 1].last = 1'b1;
        for (k = 0; k < total; k++) merged_run.push_back(slot[k]);
        fill_a = 0;
        fill_b = 0;
        drop_flag = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // input side: every accepted transaction goes through the predictor
  always @(posedge clk) begin : in_mon
    int k, n;
    if (!rst && in_valid && !in_stall) begin
      apply_item(mode, value);
      if (mode == MODE_MERGE) n_merges++;
      if (n_accepted < dir_rows.size() && dir_rows[n_accepted].n_typed >= 0) begin
        n = dir_rows[n_accepted].n_typed;
        for (k = 0; k < n; k++) pending_out.push_back(typed_out.pop_front());
      end else begin
        foreach (merged_run[k]) pending_out.push_back(merged_run[k]);
      end
      n_accepted++;
    end
  end

  always @(posedge clk) begin : out_mon
    merged_t want;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (dropped) n_drop_results++;
      if (pending_out.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value=%h b=%0d last=%0d dropped=%0d",
                 $time, merged_value, from_list_b, last, dropped);
      end else begin
        want = pending_out.pop_front();
        if (merged_value !== want.val || from_list_b !== want.from_b ||
            last !== want.last || dropped !== want.drop) begin
          errors++;
          $display("%0t: mismatch expected value=%h b=%0d last=%0d dropped=%0d",
                   $time, want.val, want.from_b, want.last, want.drop);
          $display("%0t:          actual   value=%h b=%0d last=%0d dropped=%0d",
                   $time, merged_value, from_list_b, last, dropped);
        end
      end
    end
  end

  // Receiver: random stall, plus a long hold-off whenever the stimulus asks for one.
  initial begin : receiver
    int hold_seen, hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send(logic [1:0] m, logic signed [31:0] v);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    value <= v;
    do @(posedge clk); while (in_stall);
    if (m != MODE_UNUSED) n_items++;
  endtask

  // sender pause: nothing offered until every expected result is out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_out.size() != 0) @(posedge clk);
  endtask

  task automatic dir_item(logic [1:0] m, logic signed [31:0] v, int n_typed);
    dir_rows.push_back('{m, v, n_typed});
  endtask

  task automatic dir_result(logic signed [31:0] v, logic b, logic l);
    typed_out.push_back('{v, b, l, 1'b0});
  endtask

  // Fills run_vals with n values, ascending (saturating at the top) unless ordered is clear.
  function automatic void gen_run(int n, bit ordered, longint start, longint step_max);
    longint cur;
    run_vals.delete();
    cur = start;
    repeat (n) begin
      if (ordered) run_vals.push_back(cur[31:0]);
      else run_vals.push_back($urandom);
      cur += longint'($urandom_range(0, int'(step_max)));
      if (cur > longint'(VAL_MAX)) cur = longint'(VAL_MAX);
    end
  endfunction

  function automatic longint pick_start();
    case ($urandom_range(0, 9))
      0: return longint'(VAL_MIN);
      1: return longint'(VAL_MAX) - $urandom_range(0, 50);
      default: return longint'($signed($urandom));
    endcase
  endfunction

  function automatic longint pick_step();
    case ($urandom_range(0, 3))
      0: return 2;
      1: return 1000;
      2: return 1 << 20;
      default: return 1 << 28;
    endcase
  endfunction

  // Loads two lists in random interleave with some ignored noise, then usually merges.
  task automatic run_lists(int len_a, int len_b, bit do_merge);
    logic signed [31:0] qa[$], qb[$];
    bit ordered, shared;
    longint start, step;
    ordered = ($urandom_range(0, 9) != 0);
    shared = ($urandom_range(0, 2) == 0);
    start = pick_start();
    step = pick_step();
    gen_run(len_a, ordered, start, step);
    qa = run_vals;
    if (!shared) begin
      start = pick_start();
      step = pick_step();
    end
    gen_run(len_b, ordered, start, step);
    qb = run_vals;
    while (qa.size() != 0 || qb.size() != 0) begin
      if ($urandom_range(0, 19) == 0) send(MODE_UNUSED, $urandom);
      if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(0, 1) == 1))
        send(MODE_APPEND_A, qa.pop_front());
      else
        send(MODE_APPEND_B, qb.pop_front());
    end
    if (do_merge) send(MODE_MERGE, $urandom);
  endtask

  initial begin : stimulus
    int ph, ph_start, la, lb;
    int idle_tab[4];
    int stall_tab[4];
    idle_tab = '{0, 51, 0, 29};
    stall_tab = '{0, 0, 51, 29};

    dir_item(MODE_MERGE, 32'h0, 0);              // merge on empty lists
    dir_item(MODE_APPEND_A, VAL_MIN, -1);
    dir_item(MODE_APPEND_B, VAL_MAX, -1);
    dir_item(MODE_MERGE, 32'h1357_9BDF, 2);
    dir_result(VAL_MIN, FROM_A, 1'b0);
    dir_result(VAL_MAX, FROM_B, 1'b1);
    dir_item(MODE_APPEND_B, 32'sd5, -1);
    dir_item(MODE_APPEND_A, 32'sd5, -1);
    dir_item(MODE_UNUSED, 32'hFFFF_FFFF, 0);     // mode 3 is ignored
    dir_item(MODE_MERGE, 32'h0, 2);              // tie: B goes first
    dir_result(32'sd5, FROM_B, 1'b0);
    dir_result(32'sd5, FROM_A, 1'b1);
    dir_item(MODE_APPEND_A, -32'sd1, -1);
    dir_item(MODE_MERGE, 32'hFFFF_FFFF, 1);
    dir_result(-32'sd1, FROM_A, 1'b1);
    dir_item(MODE_APPEND_B, 32'hAAAA_AAAA, -1);
    dir_item(MODE_APPEND_B, 32'h5555_5555, -1);
    dir_item(MODE_MERGE, 32'h0, 2);
    dir_result(32'hAAAA_AAAA, FROM_B, 1'b0);
    dir_result(32'h5555_5555, FROM_B, 1'b1);
    dir_item(MODE_UNUSED, 32'h0, 0);
    // unsorted list A: segments overlap
    dir_item(MODE_APPEND_A, 32'sd9, -1);
    dir_item(MODE_APPEND_A, 32'sd1, -1);
    dir_item(MODE_APPEND_B, 32'sd4, -1);
    dir_item(MODE_MERGE, 32'h0, -1);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) send(dir_rows[i].mode, dir_rows[i].value);
    drain();

    for (ph = 0; ph < 4; ph++) begin
      idle_pct = idle_tab[ph];
      stall_pct = stall_tab[ph];
      ph_start = n_items;
      if (ph == 0) begin
        // long output hold-off while both lists overflow and a merge queues up behind it
        hold_ask++;
        run_lists(33, 34, 1'b1);
        run_lists(3, 2, 1'b1);
        drain();
      end
      while (n_items - ph_start < 60) begin
        if ($urandom_range(0, 99) < 3) begin
          la = $urandom_range(30, 34);
          lb = $urandom_range(30, 34);
        end else begin
          la = $urandom_range(0, 8);
          lb = $urandom_range(0, 8);
        end
        run_lists(la, lb, $urandom_range(0, 14) != 0);
      end
      if (ph != 3) drain();
    end
    send(MODE_MERGE, $urandom);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d list transactions and %0d merges (%0d results, %0d flagged dropped),",
             n_items, n_merges, n_results, n_drop_results);
    $display("under four idle/stall mixes with one long output hold-off.");
    if (pending_out.size() != 0) $display("%0d expected results never arrived", pending_out.size());
    if (errors == 0 && pending_out.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("timeout with %0d results still expected", pending_out.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sorted_list_merge_path_unit.f =====
design/slmp_pkg.sv
design/slmp_ram.sv
design/slmp_ctrl.sv
design/slmp_dp.sv
design/sorted_list_merge_path_unit.sv
bench/tb_sorted_list_merge_path_unit.sv
